// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define GLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define GLR_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- rtl/glr_pkg.sv -----
`default_nettype none
package glr_pkg;

  localparam int unsigned MaxListLength = 65536;
  localparam int unsigned BadIdxCapInt  = (MaxListLength - 1 < 65535) ? MaxListLength - 1 : 65535;
  localparam logic [15:0] BadIdxCap     = 16'(BadIdxCapInt);
  localparam logic [15:0] CountMax      = 16'hFFFF;

  localparam logic [63:0] MinPattern    = 64'h8000_0000_0000_0000;

  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusType     = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_FOLD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] operand;
    logic        lcm;
    logic        close;
    logic        cnt_zero;
    logic        cnt_one;
    logic        type_err;
    logic [15:0] bad_idx;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_GCD,
    BK_DIV,
    BK_MUL,
    BK_FIN
  } bk_state_t;

endpackage
`default_nettype wire

// ----- rtl/glr_front.sv -----
`default_nettype none
module glr_front
  import glr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc_en,
  input  wire logic        command,
  input  wire logic [63:0] operand,
  input  wire logic        is_integer,
  input  wire logic        empty_marker,
  input  wire logic        last,
  output entry_t           entry
);

  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] fb_r, fb_nxt;
  logic        te_r, te_nxt;
  logic        mode_r, mode_nxt;

  always_comb begin
    cnt_nxt  = cnt_r;
    fb_nxt   = fb_r;
    te_nxt   = te_r;
    mode_nxt = mode_r;
    entry    = '0;
    entry.operand = operand;
    if (empty_marker) begin
      entry.op       = OP_NONE;
      entry.close    = 1'b1;
      entry.cnt_zero = (cnt_r == 16'd0);
      entry.cnt_one  = (cnt_r == 16'd1);
      entry.type_err = te_r;
      entry.bad_idx  = fb_r;
      entry.lcm      = mode_r;
    end else begin
      if (cnt_r == 16'd0) begin
        mode_nxt = command;
      end
      priority if (!is_integer) begin
        entry.op = OP_NONE;
        if (!te_r) begin
          te_nxt = 1'b1;
          fb_nxt = (cnt_r > BadIdxCap) ? BadIdxCap : cnt_r;
        end
      end else if (cnt_r == 16'd0) begin
        entry.op = OP_LOAD;
      end else if (!te_r) begin
        entry.op = OP_FOLD;
      end else begin
        entry.op = OP_NONE;
      end
      if (cnt_r != CountMax) begin
        cnt_nxt = cnt_r + 16'd1;
      end
      entry.close    = last;
      entry.cnt_zero = 1'b0;
      entry.cnt_one  = (cnt_nxt == 16'd1);
      entry.type_err = te_nxt;
      entry.bad_idx  = fb_nxt;
      entry.lcm      = mode_nxt;
    end
    if (entry.close) begin
      cnt_nxt  = '0;
      fb_nxt   = '0;
      te_nxt   = 1'b0;
      mode_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fb_r   <= '0;
      te_r   <= 1'b0;
      mode_r <= 1'b0;
    end else if (acc_en) begin
      cnt_r  <= cnt_nxt;
      fb_r   <= fb_nxt;
      te_r   <= te_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/glr_queue.sv -----
`default_nettype none
module glr_queue
  import glr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_data,
  input  wire logic   pop,
  output entry_t      head,
  output logic        full,
  output logic        empty
);

  `include "assert_macros.svh"

  entry_t                 mem_r [QueueDepth];
  logic [QueuePtrW-1:0]   wp_r, rp_r;
  logic [QueueCntW-1:0]   cnt_r;

  assign full  = (cnt_r == QueueCntW'(QueueDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QueuePtrW'(QueueDepth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QueuePtrW'(QueueDepth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + QueueCntW'(push) - QueueCntW'(pop);
    end
  end

  `GLR_ASSERT(a_cnt_bound, cnt_r <= QueueCntW'(QueueDepth), "queue count above depth")
  `GLR_ASSERT_IMP(a_no_overrun, push, !full || pop, "push into full queue")
  `GLR_ASSERT_IMP(a_no_underrun, pop, !empty, "pop from empty queue")

endmodule
`default_nettype wire

// ----- rtl/glr_back.sv -----
`default_nettype none
module glr_back
  import glr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire entry_t       head,
  input  wire logic         empty,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [63:0]       out_answer,
  output logic [1:0]        out_status,
  output logic [15:0]       out_bad_index
);

  `include "assert_macros.svh"

  bk_state_t    st_r, st_nxt;
  entry_t       cur_r, cur_nxt;
  logic [63:0]  acc_r, acc_nxt;
  logic         ovf_r, ovf_nxt;
  logic [63:0]  ma_r, ma_nxt, mb_r, mb_nxt;
  logic [63:0]  a_r, a_nxt, b_r, b_nxt;
  logic [5:0]   k_r, k_nxt;
  logic [63:0]  g_r, g_nxt;
  logic [63:0]  rem_r, rem_nxt, quo_r, quo_nxt;
  logic [5:0]   it_r, it_nxt;
  logic [127:0] prod_r, prod_nxt, qsh_r, qsh_nxt;
  logic         ov_r, ov_nxt;
  logic [63:0]  ans_r, ans_nxt;
  logic [1:0]   sts_r, sts_nxt;
  logic [15:0]  bi_r, bi_nxt;

  logic [64:0]  rem_sh;
  logic [63:0]  g_cmb;

  assign out_valid     = ov_r;
  assign out_answer    = ans_r;
  assign out_status    = sts_r;
  assign out_bad_index = bi_r;

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    it_nxt   = it_r;
    prod_nxt = prod_r;
    qsh_nxt  = qsh_r;
    ov_nxt   = ov_r & ~out_ready;
    ans_nxt  = ans_r;
    sts_nxt  = sts_r;
    bi_nxt   = bi_r;
    pop      = 1'b0;
    rem_sh   = {rem_r, quo_r[63]};
    g_cmb    = (a_r | b_r) << k_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!empty) begin
          pop     = 1'b1;
          cur_nxt = head;
          st_nxt  = BK_EXEC;
        end
      end
      BK_EXEC: begin
        st_nxt = BK_FIN;
        if (cur_r.op == OP_LOAD) begin
          acc_nxt = cur_r.operand;
        end else if (cur_r.op == OP_FOLD && !ovf_r) begin
          if (acc_r == MinPattern || cur_r.operand == MinPattern) begin
            ovf_nxt = 1'b1;
            acc_nxt = '0;
          end else begin
            ma_nxt = acc_r[63] ? 64'd0 - acc_r : acc_r;
            mb_nxt = cur_r.operand[63] ? 64'd0 - cur_r.operand : cur_r.operand;
            a_nxt  = ma_nxt;
            b_nxt  = mb_nxt;
            k_nxt  = '0;
            st_nxt = BK_GCD;
          end
        end
      end
      BK_GCD: begin
        priority if (a_r == '0 || b_r == '0) begin
          g_nxt = g_cmb;
          if (!cur_r.lcm) begin
            acc_nxt = g_cmb;
            st_nxt  = BK_FIN;
          end else if (ma_r == '0 || mb_r == '0) begin
            acc_nxt = '0;
            st_nxt  = BK_FIN;
          end else begin
            rem_nxt = '0;
            quo_nxt = ma_r;
            it_nxt  = '0;
            st_nxt  = BK_DIV;
          end
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 6'd1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r >= b_r) begin
          a_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end
      BK_DIV: begin
        if (rem_sh >= {1'b0, g_r}) begin
          rem_nxt = 64'(rem_sh - {1'b0, g_r});
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0];
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        it_nxt = it_r + 6'd1;
        if (it_r == 6'd63) begin
          prod_nxt = '0;
          qsh_nxt  = {64'd0, quo_nxt};
          it_nxt   = '0;
          st_nxt   = BK_MUL;
        end
      end
      BK_MUL: begin
        if (mb_r[0]) begin
          prod_nxt = prod_r + qsh_r;
        end
        qsh_nxt = qsh_r << 1;
        mb_nxt  = mb_r >> 1;
        it_nxt  = it_r + 6'd1;
        if (it_r == 6'd63) begin
          if (|prod_nxt[127:63]) begin
            ovf_nxt = 1'b1;
            acc_nxt = '0;
          end else begin
            acc_nxt = prod_nxt[63:0];
          end
          st_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (!cur_r.close) begin
          st_nxt = BK_IDLE;
        end else if (!ov_r || out_ready) begin
          ov_nxt  = 1'b1;
          ans_nxt = '0;
          sts_nxt = StatusOk;
          bi_nxt  = '0;
          priority if (cur_r.cnt_zero) begin
            ans_nxt = '0;
          end else if (cur_r.type_err) begin
            sts_nxt = StatusType;
            bi_nxt  = cur_r.bad_idx;
          end else if (cur_r.cnt_one) begin
            ans_nxt = acc_r;
          end else if (ovf_r) begin
            sts_nxt = StatusOverflow;
          end else begin
            ans_nxt = acc_r;
          end
          acc_nxt = '0;
          ovf_nxt = 1'b0;
          st_nxt  = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_IDLE;
      acc_r <= '0;
      ovf_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    k_r    <= k_nxt;
    g_r    <= g_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    it_r   <= it_nxt;
    prod_r <= prod_nxt;
    qsh_r  <= qsh_nxt;
    ans_r  <= ans_nxt;
    sts_r  <= sts_nxt;
    bi_r   <= bi_nxt;
  end

  `GLR_ASSERT_IMP(a_div_nonzero, st_r == BK_DIV, g_r != '0, "divide by zero gcd")
  `GLR_ASSERT_IMP(a_type_zero, ov_r && sts_r == StatusType, ans_r == '0,
                  "type error with nonzero answer")
  `GLR_ASSERT_IMP(a_pop_idle, pop, st_r == BK_IDLE, "pop outside idle")

endmodule
`default_nettype wire

// ----- rtl/list_gcd_lcm_reducer.sv -----
// GCD / LCM list reducer.
// Input words arrive on in_valid/in_ready, one list element per word, with
// in_last marking the final element; a word with in_empty_marker set closes
// the list without adding an element. The mode is taken from the first
// element. One result word leaves on out_valid/out_ready per closed list.
// A front stage accepts each word while the queue is not full, tracks count,
// mode and the first non-integer index, and pushes it into a two-word queue. The
// back stage executes words one at a time: a load or skip passes through the
// execute and finish states, a GCD fold adds binary GCD steps, and an LCM fold
// adds restoring division and shift-add multiply after the GCD steps.
// The back stage takes the next word only after finishing the current one, so
// its iterative units set the throughput. A list's result follows the
// execution of its closing word and of any words queued ahead of it. Synchronous
// active-low reset empties the queue and clears all list state. If the
// receiver stalls, the result stays in the output register; the back stage
// waits only when a second result is ready, and input words keep entering
// until the queue fills.
`default_nettype none
module list_gcd_lcm_reducer
  import glr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [63:0] in_operand,
  input  wire logic        in_is_integer,
  input  wire logic        in_empty_marker,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_answer,
  output logic [1:0]       out_status,
  output logic [15:0]      out_bad_index
);

  entry_t fe_entry, q_head;
  logic   q_full, q_empty, q_pop, in_acc;

  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  glr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc_en       (in_acc),
    .command      (in_command),
    .operand      (in_operand),
    .is_integer   (in_is_integer),
    .empty_marker (in_empty_marker),
    .last         (in_last),
    .entry        (fe_entry)
  );

  glr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (fe_entry),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  glr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_answer    (out_answer),
    .out_status    (out_status),
    .out_bad_index (out_bad_index)
  );

endmodule
`default_nettype wire

// ----- bench/list_gcd_lcm_reducer_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module list_gcd_lcm_reducer_tb;
  import glr_pkg::*;

  typedef struct {
    logic        command;
    logic [63:0] operand;
    logic        is_integer;
    logic        empty_marker;
    logic        last;
  } element_t;

  typedef struct {
    logic [63:0] answer;
    logic [1:0]  status;
    logic [15:0] bad_index;
  } reduction_t;

  class reduction_scoreboard;
    reduction_t  pending[$];
    int          failures;
    logic [63:0] acc;
    logic [15:0] count;
    logic [15:0] first_bad;
    logic        type_err;
    logic        ovf;
    logic        lcm_mode;

    function void clear_list();
      acc = '0;
      count = '0;
      first_bad = '0;
      type_err = 1'b0;
      ovf = 1'b0;
      lcm_mode = 1'b0;
    endfunction

    function new();
      failures = 0;
      clear_list();
    endfunction

    function logic [63:0] abs64(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    function logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    function void fold_element(logic [63:0] x);
      logic [63:0] ma, mb, g, q;
      if (acc == MinPattern || x == MinPattern) begin
        ovf = 1'b1;
        acc = '0;
        return;
      end
      ma = abs64(acc);
      mb = abs64(x);
      g = euclid(ma, mb);
      if (!lcm_mode) begin
        acc = g;
      end else if (ma == 0 || mb == 0) begin
        acc = '0;
      end else begin
        q = ma / g;
        if (mb > 64'h7FFF_FFFF_FFFF_FFFF / q) begin
          ovf = 1'b1;
          acc = '0;
        end else begin
          acc = q * mb;
        end
      end
    endfunction

    function void close_list();
      reduction_t r;
      r.answer = '0;
      r.status = StatusOk;
      r.bad_index = '0;
      if (count == 0) begin
        r.answer = '0;
      end else if (type_err) begin
        r.status = StatusType;
        r.bad_index = first_bad;
      end else if (count == 1) begin
        r.answer = acc;
      end else if (ovf) begin
        r.status = StatusOverflow;
      end else begin
        r.answer = acc;
      end
      pending.insert(pending.size(), r);
      clear_list();
    endfunction

    function void note_element(element_t e);
      if (e.empty_marker) begin
        close_list();
        return;
      end
      if (count == 0) lcm_mode = e.command;
      if (!e.is_integer) begin
        if (!type_err) begin
          type_err = 1'b1;
          first_bad = (count > BadIdxCap) ? BadIdxCap : count;
        end
      end else if (count == 0) begin
        acc = e.operand;
      end else if (!type_err && !ovf) begin
        fold_element(e.operand);
      end
      if (count < CountMax) count++;
      if (e.last) close_list();
    endfunction

    function void check_reduction(reduction_t got);
      reduction_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word: answer %h", got.answer);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got.answer !== want.answer) begin
        $error("answer: expected %h, actual %h", want.answer, got.answer);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.bad_index !== want.bad_index) begin
        $error("bad_index: expected %0d, actual %0d", want.bad_index, got.bad_index);
        failures++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = 1'b0;
  logic [63:0] in_operand = '0;
  logic        in_is_integer = 1'b0;
  logic        in_empty_marker = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_answer;
  logic [1:0]  out_status;
  logic [15:0] out_bad_index;

  reduction_scoreboard sb;
  int  idle_cycles = 0;
  bit  rx_stall_mode = 1'b0;
  int  burst_left = 0;

  always #2 clk = ~clk;

  list_gcd_lcm_reducer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_operand(in_operand),
    .in_is_integer(in_is_integer), .in_empty_marker(in_empty_marker),
    .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_answer(out_answer), .out_status(out_status),
    .out_bad_index(out_bad_index)
  );

  always @(posedge clk) begin
    reduction_t r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        element_t e;
        e.command = in_command;
        e.operand = in_operand;
        e.is_integer = in_is_integer;
        e.empty_marker = in_empty_marker;
        e.last = in_last;
        sb.note_element(e);
      end
      if (out_valid && out_ready) begin
        r.answer = out_answer;
        r.status = out_status;
        r.bad_index = out_bad_index;
        sb.check_reduction(r);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // The receiver alternates between a long stretch of full readiness and a stalling pattern.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_stall_mode = ~rx_stall_mode;
    if (!rx_stall_mode) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) == 0);
  end

  task automatic send_word(input element_t e);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= e.command;
    in_operand <= e.operand;
    in_is_integer <= e.is_integer;
    in_empty_marker <= e.empty_marker;
    in_last <= e.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic pause_sender();
    if (burst_left != 0) begin
      burst_left = 0;
      in_valid <= 1'b0;
    end
  endtask

  function automatic element_t make_word(logic cmd, logic [63:0] op, logic isint,
                                         logic emp, logic lst);
    element_t e;
    e.command = cmd;
    e.operand = op;
    e.is_integer = isint;
    e.empty_marker = emp;
    e.last = lst;
    return e;
  endfunction

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7FFF_FFFF_FFFF_FFFF;
      2: v = '0;
      3: v = {$urandom, $urandom};
      4: v = 64'($urandom_range(1, 1 << 20)) << $urandom_range(0, 40);
      default: v = 64'($urandom_range(1, 5000)) * 64'($urandom_range(1, 60));
    endcase
    if ($urandom_range(0, 2) == 0) v = -v;
    return v;
  endfunction

  task automatic send_list(input int len, input logic cmd);
    for (int i = 0; i < len; i++) begin
      send_word(make_word($urandom_range(0, 1) ? cmd : ~cmd, pick_operand(),
                          $urandom_range(0, 19) != 0, 1'b0, i == len - 1));
    end
  endtask

  initial begin
    int sent;
    int len;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(make_word(1'b0, '0, 1'b1, 1'b1, 1'b0));
    send_word(make_word(1'b1, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b1));
    send_word(make_word(1'b0, -64'sd12, 1'b1, 1'b0, 1'b1));
    send_word(make_word(1'b0, 64'd12, 1'b1, 1'b0, 1'b0));
    send_word(make_word(1'b1, -64'sd18, 1'b1, 1'b0, 1'b1));
    send_word(make_word(1'b1, 64'd4, 1'b1, 1'b0, 1'b0));
    send_word(make_word(1'b0, 64'd6, 1'b1, 1'b0, 1'b0));
    send_word(make_word(1'b0, '0, 1'b1, 1'b0, 1'b1));
    send_word(make_word(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0));
    send_word(make_word(1'b1, 64'd2, 1'b1, 1'b0, 1'b1));
    send_word(make_word(1'b0, 64'd5, 1'b1, 1'b0, 1'b0));
    send_word(make_word(1'b0, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0));
    send_word(make_word(1'b0, 64'd7, 1'b0, 1'b0, 1'b0));
    send_word(make_word(1'b0, 64'd7, 1'b0, 1'b0, 1'b1));
    send_word(make_word(1'b0, 64'd9, 1'b0, 1'b0, 1'b0));
    send_word(make_word(1'b1, 64'd3, 1'b1, 1'b0, 1'b0));
    send_word(make_word(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1));
    send_word(make_word(1'b1, 64'd10, 1'b1, 1'b0, 1'b0));
    send_word(make_word(1'b0, 64'd15, 1'b1, 1'b1, 1'b0));

    // Hold off until every result has come back.
    pause_sender();
    while (sb.pending.size() != 0) @(negedge clk);

    sent = 19;
    while (sent < 650) begin
      if ($urandom_range(0, 15) == 0) begin
        send_word(make_word(1'($urandom_range(0, 1)), {$urandom, $urandom},
                            1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1))));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        send_list(len, 1'($urandom_range(0, 1)));
        sent += len;
      end
    end

    pause_sender();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- list_gcd_lcm_reducer.f -----
+incdir+rtl
rtl/glr_pkg.sv
rtl/glr_front.sv
rtl/glr_queue.sv
rtl/glr_back.sv
rtl/list_gcd_lcm_reducer.sv
bench/list_gcd_lcm_reducer_tb.sv
